### src/qbez_pkg.sv
package qbez_pkg;

  // field and datapath widths
  localparam int NUM_POINTS = 6;
  localparam int DEGREE     = NUM_POINTS - 1;
  localparam int POINT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int U_W        = 17;
  localparam int CMD_W      = 3;
  localparam int FRAC_W     = 16;
  localparam int LANE_W     = POINT_W + DEGREE + 1;
  localparam int PROD_W     = LANE_W + U_W + 1;
  localparam int SCALE_W    = 8;
  localparam int SCALED_W   = LANE_W + SCALE_W + 1;
  localparam int RES_W      = 48;
  localparam int STEP_W     = 4;
  localparam int STEP_SUM_W = STEP_W + 1;

  // stage counter: difference levels run 0..DEGREE-1, interpolation rounds follow
  localparam logic [STEP_SUM_W-1:0] ROUND_END = STEP_SUM_W'(2 * DEGREE);

  localparam logic [U_W-1:0]    ONE_Q16    = U_W'(1) << FRAC_W;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

  // saturation limits, one bit wider than the result
  localparam logic signed [RES_W:0] SAT_HI = {2'b00, {(RES_W - 1){1'b1}}};
  localparam logic signed [RES_W:0] SAT_LO = {2'b11, {(RES_W - 1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_VALUE = 3'd0,
    CMD_D1    = 3'd1,
    CMD_D2    = 3'd2,
    CMD_D3    = 3'd3,
    CMD_D4    = 3'd4,
    CMD_D5    = 3'd5,
    CMD_ZERO6 = 3'd6,
    CMD_ZERO7 = 3'd7
  } cmd_t;

  typedef logic [NUM_POINTS-1:0][LANE_W-1:0] lanes_t;
  typedef logic [DEGREE-1:0][PROD_W-1:0]     prods_t;

  // one request in flight
  typedef struct packed {
    logic [U_W-1:0]    u;
    cmd_t              cmd;
    logic [STEP_W-1:0] step;
    lanes_t            c;
  } item_t;

  // request between the multiply and the add of an interpolation round
  typedef struct packed {
    item_t  it;
    prods_t p;
  } prod_t;

  // factorial factor 5!/(5-k)! for derivative order k, zero for unused codes
  function automatic logic [SCALE_W-1:0] scale_of(input cmd_t cmd);
    logic [SCALE_W-1:0] s;
    case (cmd)
      CMD_VALUE: s = SCALE_W'(1);
      CMD_D1:    s = SCALE_W'(5);
      CMD_D2:    s = SCALE_W'(20);
      CMD_D3:    s = SCALE_W'(60);
      CMD_D4:    s = SCALE_W'(120);
      CMD_D5:    s = SCALE_W'(120);
      default:   s = '0;
    endcase
    return s;
  endfunction

endpackage

### src/qbez_diff_stage.sv
module qbez_diff_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  qbez_pkg::item_t     up_item,
  output logic                dn_valid,
  input  logic                dn_ready,
  output qbez_pkg::item_t     dn_item
);

  logic            valid_r;
  qbez_pkg::item_t item_r;
  qbez_pkg::item_t item_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  // one level of forward differences while the order still asks for it
  always_comb begin
    item_nxt      = up_item;
    item_nxt.step = up_item.step + qbez_pkg::STEP_W'(1);
    if ({1'b0, up_item.cmd} > up_item.step) begin
      for (int i = 0; i < qbez_pkg::DEGREE; i++) begin
        item_nxt.c[i] = up_item.c[i + 1] - up_item.c[i];
      end
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

### src/qbez_lerp_stage.sv
module qbez_lerp_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  qbez_pkg::item_t     up_item,
  output logic                dn_valid,
  input  logic                dn_ready,
  output qbez_pkg::item_t     dn_item
);

  logic                               pv_r;
  qbez_pkg::prod_t                    prod_r;
  qbez_pkg::prod_t                    prod_nxt;
  logic                               valid_r;
  qbez_pkg::item_t                    item_r;
  qbez_pkg::item_t                    item_nxt;
  logic                               ready_add;
  logic signed [qbez_pkg::LANE_W-1:0] diff     [qbez_pkg::DEGREE];
  logic signed [qbez_pkg::PROD_W-1:0] diff_ext [qbez_pkg::DEGREE];
  logic signed [qbez_pkg::PROD_W-1:0] u_ext;
  logic signed [qbez_pkg::PROD_W-1:0] biased   [qbez_pkg::DEGREE];
  logic signed [qbez_pkg::PROD_W-1:0] rounded  [qbez_pkg::DEGREE];
  logic [qbez_pkg::STEP_SUM_W-1:0]    step_sum;

  assign ready_add = !valid_r || dn_ready;
  assign up_ready  = !pv_r || ready_add;
  assign dn_valid  = valid_r;
  assign dn_item   = item_r;

  // multiply half: (b - a) * u for each lane
  always_comb begin
    u_ext       = qbez_pkg::PROD_W'({1'b0, up_item.u});
    prod_nxt.it = up_item;
    for (int i = 0; i < qbez_pkg::DEGREE; i++) begin
      diff[i]       = $signed(up_item.c[i + 1]) - $signed(up_item.c[i]);
      diff_ext[i]   = qbez_pkg::PROD_W'(diff[i]);
      prod_nxt.p[i] = diff_ext[i] * u_ext;
    end
  end

  // add half: a + round half up of the product, while the round is live
  always_comb begin
    item_nxt      = prod_r.it;
    item_nxt.step = prod_r.it.step + qbez_pkg::STEP_W'(1);
    step_sum      = qbez_pkg::STEP_SUM_W'(prod_r.it.cmd) + {1'b0, prod_r.it.step};
    for (int i = 0; i < qbez_pkg::DEGREE; i++) begin
      biased[i]  = $signed(prod_r.p[i]) + $signed(qbez_pkg::ROUND_HALF);
      rounded[i] = biased[i] >>> qbez_pkg::FRAC_W;
    end
    if (step_sum < qbez_pkg::ROUND_END) begin
      for (int i = 0; i < qbez_pkg::DEGREE; i++) begin
        item_nxt.c[i] = prod_r.it.c[i] + rounded[i][qbez_pkg::LANE_W-1:0];
      end
    end
  end

  // valid bits of both halves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r    <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (up_ready) begin
        pv_r <= up_valid;
      end
      if (ready_add) begin
        valid_r <= pv_r;
      end
    end
  end

  // payload of both halves
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod_r <= prod_nxt;
    end
    if (ready_add && pv_r) begin
      item_r <= item_nxt;
    end
  end

endmodule

### src/qbez_scale_out.sv
module qbez_scale_out (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  qbez_pkg::item_t                   up_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [qbez_pkg::RES_W-1:0] out_result,
  output logic                              out_overflow
);

  logic                                 mv_r;
  logic signed [qbez_pkg::SCALED_W-1:0] scaled_r;
  logic signed [qbez_pkg::SCALED_W-1:0] scaled_nxt;
  logic signed [qbez_pkg::SCALED_W-1:0] lane_ext;
  logic signed [qbez_pkg::SCALED_W-1:0] scale_ext;
  logic                                 ready_out;
  logic                                 valid_r;
  logic signed [qbez_pkg::RES_W-1:0]    result_r;
  logic signed [qbez_pkg::RES_W-1:0]    result_nxt;
  logic                                 overflow_r;
  logic                                 overflow_nxt;
  logic signed [qbez_pkg::RES_W:0]      wide;

  assign ready_out    = !valid_r || out_ready;
  assign up_ready     = !mv_r || ready_out;
  assign out_valid    = valid_r;
  assign out_result   = result_r;
  assign out_overflow = overflow_r;

  // order factor
  always_comb begin
    lane_ext   = qbez_pkg::SCALED_W'($signed(up_item.c[0]));
    scale_ext  = qbez_pkg::SCALED_W'({1'b0, qbez_pkg::scale_of(up_item.cmd)});
    scaled_nxt = lane_ext * scale_ext;
  end

  // saturate to the result range
  always_comb begin
    wide = (qbez_pkg::RES_W + 1)'(scaled_r);
    if (wide > qbez_pkg::SAT_HI) begin
      result_nxt   = qbez_pkg::SAT_HI[qbez_pkg::RES_W-1:0];
      overflow_nxt = 1'b1;
    end else if (wide < qbez_pkg::SAT_LO) begin
      result_nxt   = qbez_pkg::SAT_LO[qbez_pkg::RES_W-1:0];
      overflow_nxt = 1'b1;
    end else begin
      result_nxt   = wide[qbez_pkg::RES_W-1:0];
      overflow_nxt = 1'b0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r    <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      if (up_ready) begin
        mv_r <= up_valid;
      end
      if (ready_out) begin
        valid_r <= mv_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      scaled_r <= scaled_nxt;
    end
    if (ready_out && mv_r) begin
      result_r   <= result_nxt;
      overflow_r <= overflow_nxt;
    end
  end

endmodule

### src/quintic_bezier_value_and_derivative.sv
// throughput: one request per cycle unless out_ready stalls; every stage has its
//   own valid bit, loads when empty or when its content moves on: bubbles close up
// stages: input, five difference levels, five interpolation rounds of two
//   registers (multiply, then round and add), order factor, saturation
// reset: synchronous active low, empties the pipeline and clears the control points
module quintic_bezier_value_and_derivative (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [qbez_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qbez_pkg::POINT_W-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [qbez_pkg::U_W-1:0]             in_u,
  input  logic [qbez_pkg::CMD_W-1:0]           in_command,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [qbez_pkg::RES_W-1:0]    out_result,
  output logic                                 out_overflow
);

  logic [qbez_pkg::POINT_W-1:0] point_r [qbez_pkg::NUM_POINTS];
  logic                         v0_r;
  qbez_pkg::item_t              item0_r;
  qbez_pkg::item_t              item0_nxt;

  logic            d_valid [qbez_pkg::DEGREE + 1];
  logic            d_ready [qbez_pkg::DEGREE + 1];
  qbez_pkg::item_t d_item  [qbez_pkg::DEGREE + 1];
  logic            l_valid [qbez_pkg::DEGREE + 1];
  logic            l_ready [qbez_pkg::DEGREE + 1];
  qbez_pkg::item_t l_item  [qbez_pkg::DEGREE + 1];

  // control point registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < qbez_pkg::NUM_POINTS; i++) begin
        point_r[i] <= '0;
      end
    end else if (cfg_we) begin
      for (int i = 0; i < qbez_pkg::NUM_POINTS; i++) begin
        if (cfg_index == qbez_pkg::CFG_IDX_W'(i)) begin
          point_r[i] <= cfg_data;
        end
      end
    end
  end

  // input stage: clamp u, widen the control points into lanes
  always_comb begin
    item0_nxt.u    = (in_u > qbez_pkg::ONE_Q16) ? qbez_pkg::ONE_Q16 : in_u;
    item0_nxt.cmd  = qbez_pkg::cmd_t'(in_command);
    item0_nxt.step = '0;
    for (int i = 0; i < qbez_pkg::NUM_POINTS; i++) begin
      item0_nxt.c[i] = qbez_pkg::LANE_W'($signed(point_r[i]));
    end
  end

  assign in_ready = !v0_r || d_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_ready) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item0_r <= item0_nxt;
    end
  end

  assign d_valid[0] = v0_r;
  assign d_item[0]  = item0_r;

  // forward difference levels
  for (genvar k = 0; k < qbez_pkg::DEGREE; k++) begin : g_diff
    qbez_diff_stage u_diff (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (d_valid[k]),
      .up_ready (d_ready[k]),
      .up_item  (d_item[k]),
      .dn_valid (d_valid[k + 1]),
      .dn_ready (d_ready[k + 1]),
      .dn_item  (d_item[k + 1])
    );
  end

  assign l_valid[0]             = d_valid[qbez_pkg::DEGREE];
  assign l_item[0]              = d_item[qbez_pkg::DEGREE];
  assign d_ready[qbez_pkg::DEGREE] = l_ready[0];

  // de casteljau rounds
  for (genvar r = 0; r < qbez_pkg::DEGREE; r++) begin : g_lerp
    qbez_lerp_stage u_lerp (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (l_valid[r]),
      .up_ready (l_ready[r]),
      .up_item  (l_item[r]),
      .dn_valid (l_valid[r + 1]),
      .dn_ready (l_ready[r + 1]),
      .dn_item  (l_item[r + 1])
    );
  end

  // order factor, saturation and result register
  qbez_scale_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (l_valid[qbez_pkg::DEGREE]),
    .up_ready     (l_ready[qbez_pkg::DEGREE]),
    .up_item      (l_item[qbez_pkg::DEGREE]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_result   (out_result),
    .out_overflow (out_overflow)
  );

endmodule

### src/qbez_checker.sv
module qbez_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [qbez_pkg::RES_W-1:0] out_result,
  input logic                              out_overflow
);

  // pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_overflow))
    else $error("stalled result changed");

  // 32-bit ordinates never reach the saturation limits
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_overflow)
    else $error("unexpected saturation");

  // with the sink always ready the whole pipeline moves
  a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input blocked while the sink is ready");

endmodule

bind quintic_bezier_value_and_derivative qbez_checker u_qbez_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_result   (out_result),
  .out_overflow (out_overflow)
);

### test/tb.sv
`timescale 1ns / 1ps

// one expected or observed result
typedef struct {
  logic signed [qbez_pkg::RES_W-1:0] result;
  logic                              overflow;
} curve_sample_t;

// predicts curve samples from a private copy of the ordinates and checks them in order
class curve_checker;
  localparam longint SAT_MAX = (longint'(1) <<< (qbez_pkg::RES_W - 1)) - 1;
  localparam longint SAT_MIN = -(longint'(1) <<< (qbez_pkg::RES_W - 1));

  logic signed [qbez_pkg::POINT_W-1:0] ordinate [qbez_pkg::NUM_POINTS];
  curve_sample_t                       pending_samples [$];
  int                                  mismatches;
  int                                  checked;

  function new();
    foreach (ordinate[i]) ordinate[i] = '0;
    mismatches = 0;
    checked    = 0;
  endfunction

  // de casteljau over the forward differences, one rounding per step
  function curve_sample_t eval_curve(logic [qbez_pkg::U_W-1:0] u, qbez_pkg::cmd_t cmd);
    longint        c [qbez_pkg::NUM_POINTS];
    longint        uu;
    longint        val;
    longint        factor;
    int            order;
    int            n;
    int            i;
    int            k;
    int            r;
    curve_sample_t s;
    s.result   = '0;
    s.overflow = 1'b0;
    if (cmd > qbez_pkg::CMD_D5) return s;
    order = int'(cmd);
    uu    = (u > qbez_pkg::ONE_Q16) ? longint'(qbez_pkg::ONE_Q16) : longint'(u);
    for (i = 0; i < qbez_pkg::NUM_POINTS; i++) c[i] = longint'(ordinate[i]);
    // k-th forward differences
    for (k = 1; k <= order; k++)
      for (i = 0; i < qbez_pkg::NUM_POINTS - k; i++) c[i] = c[i + 1] - c[i];
    // interpolation rounds, round half up towards plus infinity
    n = qbez_pkg::DEGREE - order;
    for (r = 0; r < n; r++)
      for (i = 0; i < n - r; i++)
        c[i] = c[i] + (((c[i + 1] - c[i]) * uu + 32768) >>> 16);
    // falling factorial 5!/(5-k)!
    factor = 1;
    for (k = 0; k < order; k++) factor = factor * (qbez_pkg::DEGREE - k);
    val = c[0] * factor;
    if (val > SAT_MAX) begin
      val        = SAT_MAX;
      s.overflow = 1'b1;
    end else if (val < SAT_MIN) begin
      val        = SAT_MIN;
      s.overflow = 1'b1;
    end
    s.result = val[qbez_pkg::RES_W-1:0];
    return s;
  endfunction

  function void note_request(logic [qbez_pkg::U_W-1:0] u, qbez_pkg::cmd_t cmd);
    pending_samples.push_back(eval_curve(u, cmd));
  endfunction

  function void check_result(logic signed [qbez_pkg::RES_W-1:0] res, logic ovf);
    curve_sample_t want;
    if (pending_samples.size() == 0) begin
      $error("result %0d arrived with no request outstanding", res);
      mismatches++;
      return;
    end
    want = pending_samples.pop_front();
    checked++;
    if (res !== want.result) begin
      $error("result: expected %0d, got %0d", want.result, res);
      mismatches++;
    end
    if (ovf !== want.overflow) begin
      $error("overflow: expected %0b, got %0b", want.overflow, ovf);
      mismatches++;
    end
  endfunction
endclass

module tb;

  localparam logic [qbez_pkg::CFG_IDX_W-1:0] REG_POINT0 = 3'd0;
  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 58;

  logic                                clk          = 1'b0;
  logic                                rst_n        = 1'b0;
  logic                                cfg_we       = 1'b0;
  logic [qbez_pkg::CFG_IDX_W-1:0]      cfg_index    = '0;
  logic [qbez_pkg::POINT_W-1:0]        cfg_data     = '0;
  logic                                in_valid     = 1'b0;
  logic                                in_ready;
  logic [qbez_pkg::U_W-1:0]            in_u         = '0;
  logic [qbez_pkg::CMD_W-1:0]          in_command   = '0;
  logic                                out_valid;
  logic                                out_ready    = 1'b0;
  logic signed [qbez_pkg::RES_W-1:0]   out_result;
  logic                                out_overflow;

  curve_checker                        sb = new();
  int                                  cycles       = 0;
  int                                  requests     = 0;
  int                                  point_sets   = 0;
  int                                  gap_max      = 0;
  int                                  stall_max    = 0;
  logic signed [qbez_pkg::POINT_W-1:0] next_ordinate [qbez_pkg::NUM_POINTS];
  logic [qbez_pkg::U_W-1:0]            edge_u [8] = '{17'd0, 17'd1, 17'd32768, 17'd65535,
                                                      17'd65536, 17'd65537, 17'd98304,
                                                      17'd131071};

  quintic_bezier_value_and_derivative u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_u         (in_u),
    .in_command   (in_command),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_result   (out_result),
    .out_overflow (out_overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // present one request after a random gap and hold it until taken
  task send_request(input logic [qbez_pkg::U_W-1:0] u, input qbez_pkg::cmd_t cmd);
    int gap;
    gap = $urandom_range(gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_u       <= u;
    in_command <= cmd;
    do @(posedge clk); while (!in_ready);
    sb.note_request(u, cmd);
    requests++;
  endtask

  // hold off new requests until every outstanding result is back
  task wait_for_results;
    in_valid <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk);
  endtask

  // write all six ordinates, only with the pipeline empty
  task load_ordinates;
    int i;
    for (i = 0; i < qbez_pkg::NUM_POINTS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= qbez_pkg::CFG_IDX_W'(REG_POINT0 + i);
      cfg_data  <= next_ordinate[i];
      @(posedge clk);
      sb.ordinate[i] = next_ordinate[i];
    end
    cfg_we <= 1'b0;
    point_sets++;
  endtask

  // result side with random back-pressure
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_result, out_overflow);
    end
  end

  initial begin
    int ph;
    int i;
    int kind;
    logic [qbez_pkg::U_W-1:0] u;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ordinates still at their reset value
    for (i = 0; i < 8; i++) send_request(edge_u[i], qbez_pkg::cmd_t'(7 - i));
    wait_for_results();

    // alternating full-scale ordinates, every command against the u corners
    for (i = 0; i < qbez_pkg::NUM_POINTS; i++)
      next_ordinate[i] = (i % 2 == 0) ? 32'sh7fffffff : 32'sh80000000;
    load_ordinates();
    for (i = 0; i < 8; i++) send_request(edge_u[i], qbez_pkg::cmd_t'(i));
    for (i = 0; i < 8; i++) send_request(edge_u[7 - i], qbez_pkg::cmd_t'(i));
    wait_for_results();

    // random phases, each with its own ordinates and idle pattern
    for (ph = 0; ph < PHASES; ph++) begin
      kind = ph % 6;
      for (i = 0; i < qbez_pkg::NUM_POINTS; i++) begin
        case (kind)
          0: next_ordinate[i] = $urandom();
          1: next_ordinate[i] = 32'sh7fffffff;
          2: next_ordinate[i] = 32'sh80000000;
          3: next_ordinate[i] = (i % 2 == (ph / 6) % 2) ? 32'sh7fffffff : 32'sh80000000;
          4: next_ordinate[i] = int'($urandom_range(2097152)) - 1048576;
          default: next_ordinate[i] = '0;
        endcase
      end
      load_ordinates();
      case (ph % 4)
        0: begin gap_max = 12; stall_max = 12; end
        1: begin gap_max = 0;  stall_max = 0;  end
        2: begin gap_max = 12; stall_max = 0;  end
        default: begin gap_max = 0; stall_max = 12; end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // mostly in range, some corners, some above one
        case ($urandom_range(9))
          0: u = ($urandom_range(1) != 0) ? qbez_pkg::ONE_Q16 : '0;
          1: u = qbez_pkg::U_W'($urandom_range(131071, 65537));
          default: u = qbez_pkg::U_W'($urandom_range(65536));
        endcase
        send_request(u, qbez_pkg::cmd_t'($urandom_range(7)));
      end
      wait_for_results();
    end

    // let anything stray show up before the verdict
    stall_max = 0;
    repeat (40) @(posedge clk);

    $display("%0d requests sent, %0d results checked, %0d ordinate sets loaded",
             requests, sb.checked, point_sets);
    $display("all commands, u from zero past the clamp, idle and stall on both sides");
    if (sb.mismatches == 0 && sb.pending_samples.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
